FILE: rtl/life_automaton_with_fade_defines.svh
// Assertion helpers used by the top-level RTL module.
`ifndef LIFE_AUTOMATON_WITH_FADE_DEFINES_SVH
`define LIFE_AUTOMATON_WITH_FADE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LFA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfa check failed");

// Next-cycle implication, disabled while reset is high.
`define LFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfa check failed");

`endif

FILE: rtl/lfa_pkg.sv
package lfa_pkg;

  localparam int GRID_WIDTH  = 8;
  localparam int GRID_HEIGHT = 8;
  localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;
  localparam int IDX_W       = $clog2(CELL_COUNT);

  localparam int COL_W   = 3;
  localparam int ROW_W   = 3;
  localparam int CMD_W   = 2;
  localparam int OPA_W   = 8;
  localparam int DIV_W   = 6;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FADE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_DIVISOR = 1'd1;

  localparam logic [OPA_W-1:0] FADE_STEP_RESET    = 8'd51;
  localparam logic [DIV_W-1:0] TICK_DIVISOR_RESET = 6'd6;
  localparam logic [OPA_W-1:0] OPA_MAX            = 8'd255;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             live_in;
  } in_item_t;

  typedef struct packed {
    logic [OPA_W-1:0] opacity;
    logic             live_out;
    logic             stepped;
  } out_item_t;

  // grid update controls
  typedef struct packed {
    logic             load_en;
    logic [IDX_W-1:0] load_idx;
    logic             load_val;
    logic             step;
  } grid_ctrl_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic             live;
  } fade_req_t;

  typedef struct packed {
    logic             valid;
    logic [OPA_W-1:0] opacity;
    logic             live;
  } fade_rsp_t;

endpackage

FILE: rtl/life_automaton_with_fade.sv
// Toroidal 8x8 life automaton with a fading opacity byte per cell. A command
// transfer happens on a rising edge with start high and busy low; its single
// result is presented on result for exactly one cycle with done high, the
// cycle after the command completes, and the receiver cannot stall it, so it
// must take every result as it appears. Load, tick and unused commands finish
// on their transfer edge, and a new command can follow in the very next cycle
// (busy stays low). A fade command reads the opacity memory into a register on
// the transfer edge and writes the saturated value back on the next edge,
// during which busy is high. A generation step is done by the whole cell array
// at once. The opacity store uses per-entry valid bits that reset clears at
// once, so no clearing pass follows reset. Configuration writes are applied on
// the edge where cfg_we is high; write them only when idle.
module life_automaton_with_fade import lfa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             item,
  output logic                 done,
  output out_item_t            result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

`include "life_automaton_with_fade_defines.svh"

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FADE = 2'b10
  } state_t;

  state_t state;

  logic [OPA_W-1:0] fade_step;
  logic [DIV_W-1:0] tick_divisor;
  logic [DIV_W-1:0] tick_count;
  logic [DIV_W-1:0] tick_count_next;

  logic             accept;
  logic             addr_ok;
  logic [IDX_W-1:0] idx;
  logic             step_now;
  logic             rd_live;
  logic             rd_next;

  grid_ctrl_t grid_ctrl;
  fade_req_t  fade_req;
  fade_rsp_t  fade_rsp;

  assign busy   = (state == ST_FADE);
  assign accept = start && !busy;

  // Address check stays general; with an 8x8 grid it always passes.
  assign addr_ok = (int'(item.col) < GRID_WIDTH) && (int'(item.row) < GRID_HEIGHT);
  assign idx     = addr_ok ? IDX_W'(int'(item.row) * GRID_WIDTH + int'(item.col)) : '0;

  // Tick counter wraps to zero once it reaches the divisor; a divisor of
  // zero therefore steps on every tick.
  always_comb begin
    tick_count_next = tick_count + DIV_W'(1);
    step_now        = (tick_count_next >= tick_divisor);
  end

  always_comb begin
    grid_ctrl.load_en  = accept && (item.cmd == CMD_LOAD) && addr_ok;
    grid_ctrl.load_idx = idx;
    grid_ctrl.load_val = item.live_in;
    grid_ctrl.step     = accept && (item.cmd == CMD_TICK) && step_now;

    fade_req.en   = accept && (item.cmd == CMD_FADE) && addr_ok;
    fade_req.idx  = idx;
    fade_req.live = rd_live;
  end

  lfa_grid u_grid (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (grid_ctrl),
    .rd_idx  (idx),
    .rd_live (rd_live),
    .rd_next (rd_next)
  );

  lfa_fade u_fade (
    .clk       (clk),
    .rst       (rst),
    .req       (fade_req),
    .fade_step (fade_step),
    .rsp       (fade_rsp)
  );

  // Config registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_step    <= FADE_STEP_RESET;
      tick_divisor <= TICK_DIVISOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FADE_STEP:    fade_step    <= cfg_data;
        REG_TICK_DIVISOR: tick_divisor <= cfg_data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // Control: state, tick counter, result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tick_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (fade_req.en) begin
              state <= ST_FADE;
            end else begin
              done <= 1'b1;
            end
            if (item.cmd == CMD_TICK) begin
              tick_count <= step_now ? '0 : tick_count_next;
            end
          end
        end
        ST_FADE: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result payload; live_out after a step comes from the cell's next value.
  // The fade unit's valid flag is high exactly in the fade write-back cycle.
  always_ff @(posedge clk) begin
    if (fade_rsp.valid) begin
      result.opacity  <= fade_rsp.opacity;
      result.live_out <= fade_rsp.live;
      result.stepped  <= 1'b0;
    end else if (accept) begin
      result.opacity <= '0;
      result.stepped <= 1'b0;
      unique case (item.cmd)
        CMD_LOAD:   result.live_out <= addr_ok && item.live_in;
        CMD_TICK: begin
          result.live_out <= addr_ok && (step_now ? rd_next : rd_live);
          result.stepped  <= step_now;
        end
        CMD_FADE:   result.live_out <= 1'b0;
        CMD_UNUSED: result.live_out <= addr_ok && rd_live;
        default:    result.live_out <= 1'b0;
      endcase
    end
  end

  // A fade transfer holds the port busy for its write-back state only.
  `LFA_ASSERT_NEXT(a_fade_busy, clk, rst, fade_req.en, busy && !done)
  `LFA_ASSERT_NEXT(a_busy_one_cycle, clk, rst, busy, !busy && done)
  // Every other transfer gives its result on the next cycle.
  `LFA_ASSERT_NEXT(a_quick_result, clk, rst, accept && !fade_req.en, done)
  // A stepped tick never carries an opacity.
  `LFA_ASSERT_NOW(a_step_no_opacity, clk, rst, done && result.stepped, result.opacity == '0)

endmodule

FILE: rtl/lfa_cell.sv
module lfa_cell import lfa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] nbr,
  input  logic       load,
  input  logic       load_val,
  input  logic       step,
  output logic       live,
  output logic       live_next
);

  logic [3:0] count;

  always_comb begin
    count = 4'd0;
    for (int i = 0; i < 8; i++) begin
      count = count + 4'(nbr[i]);
    end
    live_next = (count == 4'd3) || (live && count == 4'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (step) begin
      live <= live_next;
    end else if (load) begin
      live <= load_val;
    end
  end

endmodule

FILE: rtl/lfa_grid.sv
module lfa_grid import lfa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  grid_ctrl_t       ctrl,
  input  logic [IDX_W-1:0] rd_idx,
  output logic             rd_live,
  output logic             rd_next
);

  logic [CELL_COUNT-1:0] live;
  logic [CELL_COUNT-1:0] nxt;

  // torus: each cell sees its eight wrapped neighbors every cycle
  for (genvar y = 0; y < GRID_HEIGHT; y++) begin : g_row
    for (genvar x = 0; x < GRID_WIDTH; x++) begin : g_col
      localparam int YU = (y + GRID_HEIGHT - 1) % GRID_HEIGHT;
      localparam int YD = (y + 1) % GRID_HEIGHT;
      localparam int XL = (x + GRID_WIDTH - 1) % GRID_WIDTH;
      localparam int XR = (x + 1) % GRID_WIDTH;
      localparam int ME = y * GRID_WIDTH + x;

      logic [7:0] nbr;
      assign nbr = {live[YU*GRID_WIDTH+XL], live[YU*GRID_WIDTH+x], live[YU*GRID_WIDTH+XR],
                    live[y*GRID_WIDTH+XL],  live[y*GRID_WIDTH+XR],
                    live[YD*GRID_WIDTH+XL], live[YD*GRID_WIDTH+x], live[YD*GRID_WIDTH+XR]};

      lfa_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .nbr       (nbr),
        .load      (ctrl.load_en && (ctrl.load_idx == IDX_W'(ME))),
        .load_val  (ctrl.load_val),
        .step      (ctrl.step),
        .live      (live[ME]),
        .live_next (nxt[ME])
      );
    end
  end

  assign rd_live = live[rd_idx];
  assign rd_next = nxt[rd_idx];

endmodule

FILE: rtl/lfa_fade.sv
module lfa_fade import lfa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  fade_req_t        req,
  input  logic [OPA_W-1:0] fade_step,
  output fade_rsp_t        rsp
);

  logic [OPA_W-1:0]      mem [CELL_COUNT];
  logic [CELL_COUNT-1:0] vld;

  logic [OPA_W-1:0] rd_data;
  logic             rd_vld;
  logic [IDX_W-1:0] idx_q;
  logic             live_q;
  logic             pend;

  logic [OPA_W-1:0] cur;
  logic [OPA_W:0]   sum;
  logic [OPA_W-1:0] faded;

  // never-written entries read as zero
  always_comb begin
    cur   = rd_vld ? rd_data : '0;
    sum   = {1'b0, cur} + {1'b0, fade_step};
    if (live_q) begin
      faded = sum[OPA_W] ? OPA_MAX : sum[OPA_W-1:0];
    end else begin
      faded = (cur < fade_step) ? '0 : cur - fade_step;
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      rd_data <= mem[req.idx];
      idx_q   <= req.idx;
      live_q  <= req.live;
    end
    if (pend) begin
      mem[idx_q] <= faded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      pend   <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      pend <= req.en;
      if (req.en) begin
        rd_vld <= vld[req.idx];
      end
      if (pend) begin
        vld[idx_q] <= 1'b1;
      end
    end
  end

  assign rsp = '{valid: pend, opacity: faded, live: live_q};

endmodule

FILE: tb/lfa_result_checker.sv
`timescale 1ns / 1ps

// Watches the command, result and register write channels, keeps a shadow
// of the cell grid, opacity store and tick counter, and compares each result
// with the oldest prediction.
module lfa_result_checker import lfa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  in_item_t             item,
  input  logic                 done,
  input  out_item_t            result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   pending
);

  logic [CELL_COUNT-1:0] live_cells;
  logic [OPA_W-1:0]      opacity_mem [CELL_COUNT];
  logic [DIV_W-1:0]      tick_count;
  logic [OPA_W-1:0]      fade_step;
  logic [DIV_W-1:0]      tick_divisor;
  out_item_t             expected_results [$];
  out_item_t             want;
  out_item_t             predicted;

  // One Conway generation on the torus.
  function automatic logic [CELL_COUNT-1:0] next_generation(
    input logic [CELL_COUNT-1:0] g
  );
    logic [CELL_COUNT-1:0] nxt;
    int n;
    for (int y = 0; y < GRID_HEIGHT; y++) begin
      for (int x = 0; x < GRID_WIDTH; x++) begin
        n = 0;
        for (int dy = GRID_HEIGHT - 1; dy <= GRID_HEIGHT + 1; dy++) begin
          for (int dx = GRID_WIDTH - 1; dx <= GRID_WIDTH + 1; dx++) begin
            if (dy != GRID_HEIGHT || dx != GRID_WIDTH) begin
              n += int'(g[((y + dy) % GRID_HEIGHT) * GRID_WIDTH + (x + dx) % GRID_WIDTH]);
            end
          end
        end
        nxt[y * GRID_WIDTH + x] = (n == 3) || (g[y * GRID_WIDTH + x] && n == 2);
      end
    end
    return nxt;
  endfunction

  task automatic predict_response(input in_item_t c, output out_item_t r);
    int idx;
    logic [OPA_W:0] sum;
    idx = int'(c.row) * GRID_WIDTH + int'(c.col);
    r = '0;
    case (c.cmd)
      CMD_LOAD: live_cells[idx] = c.live_in;
      CMD_TICK: begin
        tick_count = tick_count + DIV_W'(1);
        if (tick_count >= tick_divisor) begin
          tick_count = '0;
          live_cells = next_generation(live_cells);
          r.stepped  = 1'b1;
        end
      end
      CMD_FADE: begin
        if (live_cells[idx]) begin
          sum = {1'b0, opacity_mem[idx]} + {1'b0, fade_step};
          opacity_mem[idx] = sum[OPA_W] ? OPA_MAX : sum[OPA_W-1:0];
        end else begin
          opacity_mem[idx] = (opacity_mem[idx] < fade_step) ? '0
                                                             : opacity_mem[idx] - fade_step;
        end
        r.opacity = opacity_mem[idx];
      end
      default: ;
    endcase
    r.live_out = live_cells[idx];
  endtask

  initial mismatches = 0;

  always @(posedge clk) begin
    if (rst) begin
      live_cells   = '0;
      tick_count   = '0;
      fade_step    = FADE_STEP_RESET;
      tick_divisor = TICK_DIVISOR_RESET;
      for (int i = 0; i < CELL_COUNT; i++) opacity_mem[i] = '0;
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: opacity %0d live %0b stepped %0b",
                     result.opacity, result.live_out, result.stepped);
        end else begin
          want = expected_results.pop_front();
          if (result.opacity !== want.opacity || result.live_out !== want.live_out ||
              result.stepped !== want.stepped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected opacity %0d live %0b stepped %0b, got %0d %0b %0b",
                       want.opacity, want.live_out, want.stepped,
                       result.opacity, result.live_out, result.stepped);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_FADE_STEP) fade_step = cfg_data[OPA_W-1:0];
        else if (cfg_index == REG_TICK_DIVISOR) tick_divisor = cfg_data[DIV_W-1:0];
      end
      if (start && !busy) begin
        predict_response(item, predicted);
        expected_results.push_back(predicted);
      end
    end
    pending <= expected_results.size();
  end

endmodule

FILE: tb/tb_life_automaton_with_fade.sv
`timescale 1ns / 1ps

module tb_life_automaton_with_fade;
  import lfa_pkg::*;

  localparam int RANDOM_ITEMS = 1800;
  localparam int MAX_GAP      = 12;
  // quiet cycles tolerated; worst real gap is MAX_GAP plus a fade stall
  // plus a register write pause
  localparam int IDLE_LIMIT   = 1000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  in_item_t             item;
  logic                 done;
  out_item_t            result;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   mismatches;
  int                   pending;
  int                   quiet_cycles;
  int                   sent;
  bit                   steady;   // back-to-back commands while set

  life_automaton_with_fade u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lfa_result_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .done       (done),
    .result     (result),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: any command or result transfer restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("life_automaton_with_fade test failed");
        $finish;
      end
    end
  end

  // Present one command after a random gap and hold it until the transfer.
  // start is only ever assigned once per falling edge.
  task automatic send(input in_item_t c);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    item  <= c;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input int col, input int row,
                          input bit live);
    in_item_t c;
    c.cmd     = cmd;
    c.col     = col[COL_W-1:0];
    c.row     = row[ROW_W-1:0];
    c.live_in = live;
    send(c);
  endtask

  // Registers only change with the block idle: start low, every result in,
  // and no fade write-back in progress.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Divisor upper data bits are junk on purpose; the register is 6 bits.
  task automatic set_config(input int step, input int div);
    logic [1:0] junk;
    junk = 2'($urandom_range(0, 3));
    write_reg(REG_FADE_STEP, step[OPA_W-1:0]);
    write_reg(REG_TICK_DIVISOR, {junk, div[DIV_W-1:0]});
  endtask

  task automatic random_cmd();
    int pick;
    logic [CMD_W-1:0] cmd;
    pick = $urandom_range(0, 99);
    if (pick < 30)      cmd = CMD_LOAD;
    else if (pick < 65) cmd = CMD_TICK;
    else if (pick < 95) cmd = CMD_FADE;
    else                cmd = CMD_UNUSED;
    send_cmd(cmd, $urandom_range(0, 7), $urandom_range(0, 7), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int step;
    int div;
    int burst;
    rst          = 1'b1;
    start        = 1'b0;
    item         = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    quiet_cycles = 0;
    sent         = 0;
    steady       = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed part, reset register values (step 51, divisor 6) ---
    send_cmd(CMD_FADE, 0, 0, 0);          // dead cell at 0 stays at floor
    // horizontal blinker straddling the left/right seam of row 0
    send_cmd(CMD_LOAD, 7, 0, 1);
    send_cmd(CMD_LOAD, 0, 0, 1);
    send_cmd(CMD_LOAD, 1, 0, 1);
    send_cmd(CMD_FADE, 7, 0, 1);          // live cell fades up one step
    send_cmd(CMD_UNUSED, 0, 0, 0);        // unused command just reports live bit
    repeat (6) send_cmd(CMD_TICK, $urandom_range(0, 7), $urandom_range(0, 7), 1);
    send_cmd(CMD_UNUSED, 0, 7, 1);        // blinker now vertical across top/bottom seam
    send_cmd(CMD_FADE, 7, 0, 0);          // cell died: back down to zero

    // largest step, step on every tick
    set_config(255, 1);
    send_cmd(CMD_FADE, 0, 7, 0);          // jumps to 255
    send_cmd(CMD_FADE, 0, 7, 1);          // saturates at the top
    send_cmd(CMD_TICK, 7, 7, 0);
    send_cmd(CMD_LOAD, 7, 7, 1);
    send_cmd(CMD_FADE, 7, 7, 0);
    send_cmd(CMD_LOAD, 7, 7, 0);
    send_cmd(CMD_FADE, 7, 7, 1);          // full step down from 255

    // zero divisor acts like one, zero fade step leaves opacity alone
    set_config(0, 0);
    send_cmd(CMD_TICK, 3, 4, 1);
    send_cmd(CMD_TICK, 4, 3, 0);
    send_cmd(CMD_FADE, 0, 0, 1);

    // --- random phases, each with its own register setting ---
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 4))
        0:       step = 0;
        1:       step = 255;
        2:       step = 1;
        default: step = $urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 4))
        0:       div = 0;
        1:       div = 1;
        2:       div = 63;
        default: div = $urandom_range(1, 8);
      endcase
      set_config(step, div);

      // seed a fresh population so generations have something to chew on
      repeat (16)
        send_cmd(CMD_LOAD, $urandom_range(0, 7), $urandom_range(0, 7),
                 1'($urandom_range(0, 1)));

      burst = $urandom_range(100, 180);
      repeat (burst) begin
        if ($urandom_range(0, 39) == 0) steady = !steady;
        random_cmd();
      end
    end

    // drain: wait for the last result and for any trailing fade write-back
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("life_automaton_with_fade test passed");
    end else begin
      $display("life_automaton_with_fade test failed");
    end
    $finish;
  end

endmodule
